[rtl/tgs_pkg.sv]
// ----------------------------------------------------------------------------
// tgs_pkg - shared types and constants of the touch gesture sleep engine
// Register indexes, reset values, gesture phases and fixed thresholds.
// ----------------------------------------------------------------------------
package tgs_pkg;

  // Coordinate width default and fixed screen register width
  localparam int COORD_BITS_DEF = 12;
  localparam int SCREEN_BITS    = 12;
  localparam int TIME_BITS      = 32;
  localparam int DEB_BITS       = 16;
  localparam int ID_BITS        = 4;
  localparam int PRES_BITS      = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Fixed gesture thresholds
  localparam int SWIPE_MIN_PX = 30;
  localparam logic [TIME_BITS-1:0] TAP_MAX_MS = 32'd400;

  // Register reset values
  localparam logic [TIME_BITS-1:0]   SLEEP_TIMEOUT_RST = 32'd30000;
  localparam logic [DEB_BITS-1:0]    DEBOUNCE_RST      = 16'd50;
  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST      = 12'd320;
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST      = 12'd240;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SLEEP_TIMEOUT = 3'd0,
    REG_DEBOUNCE      = 3'd1,
    REG_SWAP_AXES     = 3'd2,
    REG_INVERT_X      = 3'd3,
    REG_INVERT_Y      = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6,
    REG_SUPPRESS_WAKE = 3'd7
  } cfg_reg_t;

  // Gesture phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DRAG  = 2'd2
  } phase_t;

endpackage

[rtl/touch_gesture_sleep_engine.sv]
// ----------------------------------------------------------------------------
// touch_gesture_sleep_engine - per-frame touch calibration, gestures, sleep
// An accepted input item is held in the input register, then moves to the result register.
// Throughput: 1 item per cycle; input register, one pass of compare and
// subtract logic, result register, both advancing whenever the result is free.
// Reset (rst, synchronous, active high): registers return to their defaults,
// gesture phase to idle, sleep and wake trap cleared, both stages empty.
// ----------------------------------------------------------------------------
module touch_gesture_sleep_engine #(
  parameter int COORD_BITS = tgs_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [tgs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tgs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input frame channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               touch_present,
  input  logic [COORD_BITS-1:0]              raw_x,
  input  logic [COORD_BITS-1:0]              raw_y,
  input  logic [tgs_pkg::ID_BITS-1:0]        touch_id,
  input  logic [tgs_pkg::PRES_BITS-1:0]      touch_pressure,
  input  logic [tgs_pkg::TIME_BITS-1:0]      now_ms,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               point_valid,
  output logic [COORD_BITS-1:0]              out_x,
  output logic [COORD_BITS-1:0]              out_y,
  output logic [tgs_pkg::ID_BITS-1:0]        out_id,
  output logic [tgs_pkg::PRES_BITS-1:0]      out_pressure,
  output logic                               clear_points,
  output logic                               sleep_event,
  output logic                               wake_event,
  output logic                               tap_event,
  output logic                               swipe_left_event,
  output logic                               swipe_right_event
);

  localparam int TB = tgs_pkg::TIME_BITS;
  // Mirror arithmetic width: wide enough for coordinate and screen size plus sign
  localparam int MB = ((COORD_BITS > tgs_pkg::SCREEN_BITS) ? COORD_BITS
                                                           : tgs_pkg::SCREEN_BITS) + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TB-1:0]                       sleep_timeout_ms;
  logic [tgs_pkg::DEB_BITS-1:0]        tap_min_ms;
  logic                                swap_axes;
  logic                                invert_x;
  logic                                invert_y;
  logic [tgs_pkg::SCREEN_BITS-1:0]     screen_width;
  logic [tgs_pkg::SCREEN_BITS-1:0]     screen_height;
  logic                                suppress_wake_touch;

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_timeout_ms    <= tgs_pkg::SLEEP_TIMEOUT_RST;
      tap_min_ms          <= tgs_pkg::DEBOUNCE_RST;
      swap_axes           <= 1'b0;
      invert_x            <= 1'b0;
      invert_y            <= 1'b0;
      screen_width        <= tgs_pkg::SCREEN_W_RST;
      screen_height       <= tgs_pkg::SCREEN_H_RST;
      suppress_wake_touch <= 1'b0;
    end else if (cfg_we) begin
      // Every index of the port names a register; each takes its low bits
      case (tgs_pkg::cfg_reg_t'(cfg_index))
        tgs_pkg::REG_SLEEP_TIMEOUT: sleep_timeout_ms    <= cfg_data[TB-1:0];
        tgs_pkg::REG_DEBOUNCE:      tap_min_ms          <= cfg_data[tgs_pkg::DEB_BITS-1:0];
        tgs_pkg::REG_SWAP_AXES:     swap_axes           <= cfg_data[0];
        tgs_pkg::REG_INVERT_X:      invert_x            <= cfg_data[0];
        tgs_pkg::REG_INVERT_Y:      invert_y            <= cfg_data[0];
        tgs_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[tgs_pkg::SCREEN_BITS-1:0];
        tgs_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[tgs_pkg::SCREEN_BITS-1:0];
        tgs_pkg::REG_SUPPRESS_WAKE: suppress_wake_touch <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: the input register moves into the result register
  // whenever the result register is empty or being drained this cycle.
  // --------------------------------------------------------------------------
  logic ir_valid;
  logic advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !ir_valid || advance;

  // Input register (payload needs no reset)
  logic                           ir_present;
  logic [COORD_BITS-1:0]          ir_x;
  logic [COORD_BITS-1:0]          ir_y;
  logic [tgs_pkg::ID_BITS-1:0]    ir_id;
  logic [tgs_pkg::PRES_BITS-1:0]  ir_pres;
  logic [TB-1:0]                  ir_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_present <= touch_present;
      ir_x       <= raw_x;
      ir_y       <= raw_y;
      ir_id      <= touch_id;
      ir_pres    <= touch_pressure;
      ir_now     <= now_ms;
    end
  end

  // Process the held frame exactly once, as it leaves the input register
  logic fire;
  assign fire = ir_valid && advance;

  // --------------------------------------------------------------------------
  // Engine state
  // --------------------------------------------------------------------------
  tgs_pkg::phase_t        phase, phase_next;
  logic [COORD_BITS-1:0]  start_x, start_x_next;
  logic [TB-1:0]          press_start_ms, press_start_ms_next;
  logic [TB-1:0]          last_activity_ms, last_activity_ms_next;
  logic                   asleep, asleep_next;
  logic                   wake_trap, wake_trap_next;

  // --------------------------------------------------------------------------
  // Shared datapath: sleep timer, calibration, tap timing and swipe distance
  // --------------------------------------------------------------------------
  logic [TB-1:0]          idle_ms;
  logic                   go_sleep;
  logic                   asleep_mid;
  logic                   wake;
  logic                   trap_set;
  logic                   deliver;
  logic [TB-1:0]          press_ms;
  logic                   tap_ok;
  logic [COORD_BITS-1:0]  sw_x, sw_y;
  logic [tgs_pkg::SCREEN_BITS-1:0] size_x, size_y;
  logic [MB-1:0]          mir_x, mir_y;
  logic [COORD_BITS-1:0]  cal_x, cal_y;
  logic [COORD_BITS:0]    dx;
  logic [COORD_BITS:0]    adx;
  logic                   swipe;

  // Inactivity is measured modulo 2^32
  assign idle_ms    = ir_now - last_activity_ms;
  assign go_sleep   = (idle_ms > sleep_timeout_ms) && !asleep;
  assign asleep_mid = asleep || go_sleep;

  // A touch while asleep wakes; the waking touch may be trapped until release
  assign wake     = ir_present && asleep_mid;
  assign trap_set = wake && suppress_wake_touch;
  assign deliver  = ir_present && !trap_set && !wake_trap;

  // Tap window: minimum press time <= press time < fixed maximum
  assign press_ms = ir_now - press_start_ms;
  assign tap_ok   = (press_ms >= TB'(tap_min_ms)) && (press_ms < tgs_pkg::TAP_MAX_MS);

  // Swap first; with swapped axes x mirrors against the height
  assign sw_x   = swap_axes ? ir_y : ir_x;
  assign sw_y   = swap_axes ? ir_x : ir_y;
  assign size_x = swap_axes ? screen_height : screen_width;
  assign size_y = swap_axes ? screen_width  : screen_height;

  // Mirror, then clamp negative results at zero
  assign mir_x = MB'(size_x) - MB'(sw_x);
  assign mir_y = MB'(size_y) - MB'(sw_y);

  always_comb begin
    cal_x = sw_x;
    cal_y = sw_y;
    if (invert_x) begin
      cal_x = mir_x[MB-1] ? '0 : mir_x[COORD_BITS-1:0];
    end
    if (invert_y) begin
      cal_y = mir_y[MB-1] ? '0 : mir_y[COORD_BITS-1:0];
    end
  end

  // Horizontal travel since press, as a signed value one bit wider
  assign dx    = {1'b0, cal_x} - {1'b0, start_x};
  assign adx   = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign swipe = adx > (COORD_BITS + 1)'(tgs_pkg::SWIPE_MIN_PX);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next            = phase;
    start_x_next          = start_x;
    press_start_ms_next   = press_start_ms;
    last_activity_ms_next = last_activity_ms;
    asleep_next           = asleep_mid;
    wake_trap_next        = wake_trap;
    if (!ir_present) begin
      // Release: drop any gesture and free the wake trap
      phase_next     = tgs_pkg::PH_IDLE;
      wake_trap_next = 1'b0;
    end else begin
      asleep_next           = 1'b0;
      last_activity_ms_next = ir_now;
      if (trap_set) begin
        wake_trap_next = 1'b1;
      end
      if (deliver) begin
        case (phase)
          tgs_pkg::PH_IDLE: begin
            phase_next          = tgs_pkg::PH_START;
            start_x_next        = cal_x;
            press_start_ms_next = ir_now;
          end
          tgs_pkg::PH_START: begin
            if (swipe) begin
              phase_next = tgs_pkg::PH_DRAG;
            end
          end
          default: ;  // dragging holds until release
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result item
  // --------------------------------------------------------------------------
  logic                           r_point_valid;
  logic [COORD_BITS-1:0]          r_x, r_y;
  logic [tgs_pkg::ID_BITS-1:0]    r_id;
  logic [tgs_pkg::PRES_BITS-1:0]  r_pres;
  logic                           r_clear, r_sleep, r_wake, r_tap, r_left, r_right;

  always_comb begin
    r_point_valid = deliver;
    r_x           = deliver ? cal_x   : '0;
    r_y           = deliver ? cal_y   : '0;
    r_id          = deliver ? ir_id   : '0;
    r_pres        = deliver ? ir_pres : '0;
    r_sleep       = go_sleep;
    r_wake        = wake;
    r_clear       = 1'b0;
    r_tap         = 1'b0;
    r_left        = 1'b0;
    r_right       = 1'b0;
    if (!ir_present) begin
      r_clear = (phase != tgs_pkg::PH_IDLE);
      r_tap   = (phase == tgs_pkg::PH_START) && tap_ok;
    end else if (deliver && (phase == tgs_pkg::PH_START) && swipe) begin
      r_right = !dx[COORD_BITS] && (dx != '0);
      r_left  = !r_right;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tgs_pkg::PH_IDLE;
      start_x          <= '0;
      press_start_ms   <= '0;
      last_activity_ms <= '0;
      asleep           <= 1'b0;
      wake_trap        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        phase            <= phase_next;
        start_x          <= start_x_next;
        press_start_ms   <= press_start_ms_next;
        last_activity_ms <= last_activity_ms_next;
        asleep           <= asleep_next;
        wake_trap        <= wake_trap_next;
      end
      if (advance) begin
        out_valid <= ir_valid;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      point_valid       <= r_point_valid;
      out_x             <= r_x;
      out_y             <= r_y;
      out_id            <= r_id;
      out_pressure      <= r_pres;
      clear_points      <= r_clear;
      sleep_event       <= r_sleep;
      wake_event        <= r_wake;
      tap_event         <= r_tap;
      swipe_left_event  <= r_left;
      swipe_right_event <= r_right;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A tap is only reported on a release that ends a gesture
  a_tap_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tap_event) |-> (clear_points && !point_valid))
    else $error("tap without clear on release");

  // A swipe comes with a delivered point and only one direction
  a_swipe_point: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (swipe_left_event || swipe_right_event)) |->
      (point_valid && !(swipe_left_event && swipe_right_event)))
    else $error("swipe without point or with both directions");

  // The wake trap only exists on an awake block
  a_trap_awake: assert property (@(posedge clk) disable iff (rst)
    wake_trap |-> !asleep)
    else $error("wake trap set while asleep");

  // A processed touch frame always leaves the block awake
  a_touch_wakes: assert property (@(posedge clk) disable iff (rst)
    (fire && ir_present) |=> !asleep)
    else $error("asleep after a touch frame");

endmodule
